[src/assert_macros.svh]
// Assertion macros used by the checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CEX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cex checker: same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define CEX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cex checker: next-cycle implication failed");

`endif

[src/cex_pkg.sv]
// Shared types and constants of the caliper extremum detector.
// No dependencies; imported by every module of the block but the checker.
`default_nettype none

package cex_pkg;

  localparam int PIX_W  = 8;
  localparam int IDX_W  = 13;
  localparam int THR_W  = 9;
  localparam int POS_W  = 16;
  localparam int WT_W   = 8;
  localparam int DSUM_W = PIX_W + 1;
  localparam int DEN_W  = 22;            // dsum * width, < 2^22
  localparam int MUL_W  = DEN_W + 1;     // signed multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int VAL_W  = 41;            // signed numerator of the range map
  localparam int DSH_W  = DEN_W + POS_W; // divisor shifted to the top bit
  localparam int CNT_W  = $clog2(POS_W);
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 16;

  localparam logic [PIX_W-1:0] WHITE = '1;

  localparam logic [1:0] POL_RISE = 2'd1;
  localparam logic [1:0] POL_FALL = 2'd2;

  typedef enum logic [CIDX_W-1:0] {
    REG_THR   = 3'd0,
    REG_BACK  = 3'd1,
    REG_POL   = 3'd2,
    REG_WIDTH = 3'd3,
    REG_LOW   = 3'd4,
    REG_HIGH  = 3'd5
  } cfg_reg_t;

  // run length class: none yet, zero, above zero
  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_ZERO = 2'd1,
    RUN_POS  = 2'd2
  } run_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic              back;
    logic [1:0]        pol;
    logic [IDX_W-1:0]  width;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [PIX_W-1:0]  d1;
    logic [DSUM_W-1:0] dsum;
    logic [WT_W-1:0]   weight;
    logic              falling;
  } feat_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [WT_W-1:0]  weight;
    logic             falling;
  } res_t;

endpackage

`default_nettype wire

[src/cex_alu.sv]
// Shared arithmetic unit: registered signed multiplier and a wide subtractor.
// Depends on cex_pkg.
`default_nettype none

module cex_alu
  import cex_pkg::*;
(
  input  wire                     clk,
  input  wire  signed [MUL_W-1:0] mul_a,
  input  wire  signed [MUL_W-1:0] mul_b,
  input  wire  signed [VAL_W-1:0] sub_a,
  input  wire  signed [VAL_W-1:0] sub_b,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [VAL_W-1:0]  diff
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;
  assign diff = sub_a - sub_b;

endmodule

`default_nettype wire

[src/cex_scan.sv]
// Line tracker: last two pixels, index, run classes and feature detection.
// Depends on cex_pkg.
`default_nettype none

module cex_scan
  import cex_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              accept,
  input  wire  [PIX_W-1:0] pixel,
  input  wire              last,
  input  cfg_t             cfg,
  output logic             hit,
  output feat_t            feat
);

  logic [PIX_W-1:0] cur_r, prev_r;
  logic             idx_ok_r;
  logic [IDX_W-1:0] idx_r, spos_r;
  run_t             rise_r, fall_r;

  logic               drop, up, low, peak, valley;
  logic [17:0]        up_lhs, up_rhs;
  logic signed [19:0] lo_lhs, lo_rhs;
  logic [PIX_W-1:0]   d1, d2;
  logic [PIX_W:0]     dbl;
  logic [IDX_W-1:0]   wm1, start_pos;

  function automatic run_t bump(input run_t r);
    run_t b;
    unique case (r)
      RUN_NONE: b = RUN_ZERO;
      RUN_ZERO: b = RUN_POS;
      default:  b = RUN_POS;
    endcase
    return b;
  endfunction

  always_comb begin
    drop   = pixel < cur_r;
    // thresholds (0.5 +- 0.5w) * white, compared exactly
    up_lhs = {1'b0, cur_r, 9'b0};
    up_rhs = 18'(WHITE) * (18'(cfg.thr) + 18'd256);
    lo_lhs = $signed({3'b0, cur_r, 9'b0});
    lo_rhs = $signed({12'b0, WHITE}) * (20'sd256 - $signed({11'b0, cfg.thr}));
    up     = up_lhs > up_rhs;
    low    = lo_lhs < lo_rhs;
    peak   = drop && (cfg.pol != POL_FALL) && (rise_r == RUN_POS) && up;
    valley = !drop && (cfg.pol != POL_RISE) && (fall_r == RUN_POS) && low;
    hit    = peak || valley;

    d1  = drop ? cur_r - prev_r : prev_r - cur_r;
    d2  = drop ? cur_r - pixel : pixel - cur_r;
    dbl = {cur_r, 1'b0};

    feat.idx     = idx_r;
    feat.d1      = d1;
    feat.dsum    = {1'b0, d1} + {1'b0, d2};
    feat.weight  = drop ? WT_W'(dbl - {1'b0, WHITE}) : WT_W'({1'b0, WHITE} - dbl);
    feat.falling = !drop;

    wm1       = (cfg.width == '0) ? '0 : cfg.width - 1'b1;
    start_pos = idx_ok_r ? spos_r : (cfg.back ? wm1 : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      prev_r   <= '0;
      idx_ok_r <= 1'b0;
      idx_r    <= '0;
      spos_r   <= '0;
      rise_r   <= RUN_NONE;
      fall_r   <= RUN_NONE;
    end else if (accept) begin
      if (last) begin
        cur_r    <= '0;
        prev_r   <= '0;
        idx_ok_r <= 1'b0;
        idx_r    <= '0;
        spos_r   <= '0;
        rise_r   <= RUN_NONE;
        fall_r   <= RUN_NONE;
      end else begin
        prev_r   <= cur_r;
        cur_r    <= pixel;
        idx_ok_r <= 1'b1;
        idx_r    <= start_pos;
        if (cfg.back) begin
          spos_r <= (start_pos != '0) ? start_pos - 1'b1 : start_pos;
        end else begin
          spos_r <= (start_pos != '1) ? start_pos + 1'b1 : start_pos;
        end
        if (drop) begin
          rise_r <= RUN_ZERO;
          fall_r <= bump(fall_r);
        end else begin
          rise_r <= bump(rise_r);
          fall_r <= RUN_ZERO;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/cex_pos.sv]
// Position sequencer: range map and restoring division on the shared unit.
// Depends on cex_pkg and cex_alu.
`default_nettype none

module cex_pos
  import cex_pkg::*;
(
  input  wire    clk,
  input  wire    rst_n,
  input  wire    start,
  input  feat_t  feat,
  input  cfg_t   cfg,
  input  wire    res_ready,
  output logic   busy,
  output logic   res_valid,
  output res_t   res
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MDEN  = 9'b000000010,
    S_MNUM  = 9'b000000100,
    S_MLO   = 9'b000001000,
    S_MSPAN = 9'b000010000,
    S_SUM   = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]        idx_r;
  logic [PIX_W-1:0]        d1_r;
  logic [DSUM_W-1:0]       dsum_r;
  logic [WT_W-1:0]         wt_r;
  logic                    fall_r;
  logic [DEN_W-1:0]        den_r, num_r;
  logic signed [VAL_W-1:0] val_r, rem_r;
  logic [DSH_W-1:0]        dsh_r;
  logic [POS_W-1:0]        q_r;
  logic [CNT_W-1:0]        cnt_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [VAL_W-1:0]  sub_a, sub_b, diff;
  logic signed [PROD_W-1:0] prod;
  logic [IDX_W-1:0]         weff;
  logic signed [POS_W:0]    span;
  logic                     val_le0;

  cex_alu u_alu (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .sub_a (sub_a),
    .sub_b (sub_b),
    .prod  (prod),
    .diff  (diff)
  );

  always_comb begin
    weff    = (cfg.width == '0) ? IDX_W'(1) : cfg.width;
    span    = $signed({1'b0, cfg.hi}) - $signed({1'b0, cfg.lo});
    val_le0 = val_r[VAL_W-1] || (val_r == '0);
    mul_a   = '0;
    mul_b   = '0;
    sub_a   = '0;
    sub_b   = '0;
    unique case (state_r)
      S_MDEN: begin
        mul_a = $signed({(MUL_W-DSUM_W)'(0), dsum_r});
        mul_b = $signed({(MUL_W-IDX_W)'(0), weff});
      end
      S_MNUM: begin
        mul_a = $signed({(MUL_W-IDX_W)'(0), idx_r});
        mul_b = $signed({(MUL_W-DSUM_W)'(0), dsum_r});
      end
      S_MLO: begin
        mul_a = $signed({(MUL_W-POS_W)'(0), cfg.lo});
        mul_b = $signed({1'b0, den_r});
      end
      S_MSPAN: begin
        mul_a = MUL_W'(span);
        mul_b = $signed({1'b0, num_r});
      end
      S_CHK: begin
        sub_a = val_r;
        sub_b = $signed({(VAL_W-DSH_W)'(0), den_r, POS_W'(0)});
      end
      S_DIV: begin
        sub_a = rem_r;
        sub_b = $signed({(VAL_W-DSH_W)'(0), dsh_r});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MDEN;
      S_MDEN:  state_nxt = S_MNUM;
      S_MNUM:  state_nxt = S_MLO;
      S_MLO:   state_nxt = S_MSPAN;
      S_MSPAN: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_CHK;
      S_CHK:   state_nxt = (val_le0 || !diff[VAL_W-1]) ? S_DONE : S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_DONE;
      S_DONE:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_r  <= feat.idx;
          d1_r   <= feat.d1;
          dsum_r <= feat.dsum;
          wt_r   <= feat.weight;
          fall_r <= feat.falling;
        end
      end
      S_MNUM:  den_r <= prod[DEN_W-1:0];
      S_MLO:   num_r <= prod[DEN_W-1:0] + DEN_W'(d1_r);
      S_MSPAN: val_r <= prod[VAL_W-1:0];
      S_SUM:   val_r <= val_r + prod[VAL_W-1:0];
      S_CHK: begin
        // clamp at zero, saturate when quotient would need a 17th bit
        if (val_le0) begin
          q_r <= '0;
        end else if (!diff[VAL_W-1]) begin
          q_r <= '1;
        end else begin
          q_r <= '0;
        end
        rem_r <= val_r;
        dsh_r <= {1'b0, den_r, (POS_W-1)'(0)};
        cnt_r <= CNT_W'(POS_W - 1);
      end
      S_DIV: begin
        if (!diff[VAL_W-1]) rem_r <= diff;
        q_r   <= {q_r[POS_W-2:0], !diff[VAL_W-1]};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign busy         = (state_r != S_IDLE);
  assign res_valid    = (state_r == S_DONE);
  assign res.position = q_r;
  assign res.weight   = wt_r;
  assign res.falling  = fall_r;

endmodule

`default_nettype wire

[src/caliper_extremum_detector.sv]
// Top level of the caliper extremum detector: config registers, output stage.
// Depends on cex_pkg, cex_scan, cex_pos (and cex_alu below it).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | request   | in_valid/in_stall  | pixel_value[7:0], last_pixel
//  out_    | result    | out_valid/out_stall| edge_position[15:0], edge_weight[7:0],
//          |           |                    | is_falling
//  cfg_    | write     | cfg_valid/cfg_ready| cfg_index[2:0], cfg_data[15:0]
//
// A pixel that raises no feature leaves the sequencer idle; the next request can
// follow immediately.
// A pixel that raises a feature holds in_stall while the sequencer runs: four
// products on the shared multiplier, one accumulate, one range check and 16
// restoring division steps on the shared subtractor (none when the position
// clamps at zero or saturates), then a done state that hands the result to
// the output register.
// The output register parts the sides: a new request is taken while a
// result waits under out_stall; a finished feature waits in the sequencer.
// Synchronous active-low reset clears line state and valid flags and loads config defaults.
`default_nettype none

module caliper_extremum_detector
  import cex_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [PIX_W-1:0]  in_pixel_value,
  input  wire               in_last_pixel,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [POS_W-1:0]  out_edge_position,
  output logic [WT_W-1:0]   out_edge_weight,
  output logic              out_is_falling,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [CIDX_W-1:0] cfg_index,
  input  wire  [CDAT_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  accept, hit, busy, res_valid, res_ready;
  feat_t feat;
  res_t  res;
  res_t  out_r;
  logic  out_valid_r;

  // config must only be written while no request is in flight; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr   <= '0;
      cfg_r.back  <= 1'b0;
      cfg_r.pol   <= '0;
      cfg_r.width <= IDX_W'(4096);
      cfg_r.lo    <= '0;
      cfg_r.hi    <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THR:   cfg_r.thr   <= cfg_data[THR_W-1:0];
        REG_BACK:  cfg_r.back  <= cfg_data[0];
        REG_POL:   cfg_r.pol   <= cfg_data[1:0];
        REG_WIDTH: cfg_r.width <= cfg_data[IDX_W-1:0];
        REG_LOW:   cfg_r.lo    <= cfg_data[POS_W-1:0];
        REG_HIGH:  cfg_r.hi    <= cfg_data[POS_W-1:0];
        default: ; // unused indexes are ignored
      endcase
    end
  end

  // sequencer busy blocks new requests; line state updates on accept
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  cex_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .pixel  (in_pixel_value),
    .last   (in_last_pixel),
    .cfg    (cfg_r),
    .hit    (hit),
    .feat   (feat)
  );

  cex_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept && hit),
    .feat      (feat),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_edge_position = out_r.position;
  assign out_edge_weight   = out_r.weight;
  assign out_is_falling    = out_r.falling;

endmodule

`default_nettype wire

[src/cex_checker.sv]
// Port-level checker for the caliper extremum detector, bound to the top.
// Depends on assert_macros.svh and the top level's port names.
`default_nettype none
`include "assert_macros.svh"

module cex_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] out_edge_position,
  input wire [7:0]  out_edge_weight,
  input wire        out_is_falling
);

  wire [24:0] out_word = {out_edge_position, out_edge_weight, out_is_falling};

  `CEX_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `CEX_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_word))
  // a result only appears after the sequencer held off the input
  `CEX_ASSERT_IMP(a_rise_after_busy, $rose(out_valid), $past(in_stall))
  // weight is 2p-white or white-2p with white odd, so it is always odd
  `CEX_ASSERT_IMP(a_weight_odd, out_valid, out_edge_weight[0])

endmodule

bind caliper_extremum_detector cex_checker u_cex_checker (.*);

`default_nettype wire
